>>> rtl/core/grv_pkg.sv
// Shared types, constants and the ray direction function for the visibility score core.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps
package grv_pkg;

   // Register indexes on the CSR port
   localparam logic [1:0] CSR_MAP_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_MAP_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_MAX_STEPS  = 2'd2;
   localparam logic [1:0] CSR_THRESHOLD  = 2'd3;

   // Request modes
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam int POS_W   = 28;   // ray position, signed, 16 fraction bits
   localparam int FRAC_W  = 16;
   localparam int DIM_W   = 13;   // effective map size, clamped to MAX_WIDTH/MAX_HEIGHT
   localparam int STEP_W  = 10;
   localparam int DIR_W   = 17;   // signed Q15 direction component
   localparam int SCORE_W = 17;
   localparam int NUM_W   = 18;
   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = 1;

   localparam logic [STEP_W-1:0] RST_DIM       = 10'd512;
   localparam logic [STEP_W-1:0] RST_MAX_STEPS = 10'd200;
   localparam logic [7:0]        RST_THRESHOLD = 8'd50;

   typedef struct packed {
      logic       is_query;
      logic       in_range;
      logic       obst;
      logic       restart;
      logic [8:0] x;
      logic [8:0] y;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_START, ST_WALK, ST_RAYEND, ST_MUL, ST_DIV, ST_FIN, ST_OUT
   } back_state_type;

   // Round a Q30 value to Q15, saturating at one
   function automatic logic [DIR_W-1:0] q15_of(input longint v);
      longint r;
      r = (v + 64'sd16384) >>> 15;
      if (r > 64'sd32768) r = 64'sd32768;
      return DIR_W'(r);
   endfunction

   // Unit direction {dx, dy} for an angle phase in turns (2^32 per turn)
   function automatic logic [2*DIR_W-1:0] dir_of(input logic [31:0] t);
      logic [63:0]      r, x, x2, ts, tc;
      longint           ss, sc;
      logic [DIR_W-1:0] s, c, dx, dy;
      r  = {34'd0, t[29:0]};
      x  = (r * 64'd1686629713) >> 30;
      x2 = (x * x) >> 30;
      ts = x;
      ss = longint'(ts);
      ts = ((ts * x2) >> 30) / 6;   ss = ss - longint'(ts);
      ts = ((ts * x2) >> 30) / 20;  ss = ss + longint'(ts);
      ts = ((ts * x2) >> 30) / 42;  ss = ss - longint'(ts);
      ts = ((ts * x2) >> 30) / 72;  ss = ss + longint'(ts);
      ts = ((ts * x2) >> 30) / 110; ss = ss - longint'(ts);
      ts = ((ts * x2) >> 30) / 156; ss = ss + longint'(ts);
      ts = ((ts * x2) >> 30) / 210; ss = ss - longint'(ts);
      tc = 64'd1 << 30;
      sc = longint'(tc);
      tc = ((tc * x2) >> 30) / 2;   sc = sc - longint'(tc);
      tc = ((tc * x2) >> 30) / 12;  sc = sc + longint'(tc);
      tc = ((tc * x2) >> 30) / 30;  sc = sc - longint'(tc);
      tc = ((tc * x2) >> 30) / 56;  sc = sc + longint'(tc);
      tc = ((tc * x2) >> 30) / 90;  sc = sc - longint'(tc);
      tc = ((tc * x2) >> 30) / 132; sc = sc + longint'(tc);
      tc = ((tc * x2) >> 30) / 182; sc = sc - longint'(tc);
      if (ss < 0) ss = 0;
      if (sc < 0) sc = 0;
      s = q15_of(ss);
      c = q15_of(sc);
      case (t[31:30])
         2'd0: begin dx = c;  dy = s;  end
         2'd1: begin dx = -s; dy = c;  end
         2'd2: begin dx = -c; dy = -s; end
         default: begin dx = s; dy = -c; end
      endcase
      return {dx, dy};
   endfunction

endpackage

>>> rtl/core/grid_raycast_visibility_score_core.sv
// Top level of the occupancy-grid visibility score core: CSRs, front end and ray walker.
// Depends on grv_pkg, grv_front and grv_back.
//
//   Channel | Ports                | Direction | Beat
//   req     | req_valid/req_ready  | in        | one map write or one query
//   rsp     | rsp_valid/rsp_ready  | out       | one score per query, none per write
//   csr     | csr_we               | in        | one register write, no wait
//
// A write is applied from the idle state. For a query the walker reads one grid cell
// per half-cell step of each of the NUM_RAYS rays from its single read port, then
// divides one bit a cycle.
// Reset is synchronous; the grid holds no reset value and must be written first.
// The two-entry request queue keeps accepting while a result waits on rsp_ready, until it is full.
`timescale 1ns / 1ps
module grid_raycast_visibility_score_core import grv_pkg::*; #(
   parameter int NUM_RAYS   = 36,
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_mode,
   input  logic [8:0]          req_cell_x,
   input  logic [8:0]          req_cell_y,
   input  logic signed [7:0]   req_occupancy,
   input  logic                req_restart_numbering,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SCORE_W-1:0]  rsp_point_score,
   output logic                rsp_accepted,
   output logic [NUM_W-1:0]    rsp_point_number,
   output logic [5:0]          rsp_valid_rays,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [STEP_W-1:0]   csr_wdata
);

   logic [STEP_W-1:0] map_width_ff, map_height_ff, max_steps_ff;
   logic [7:0]        threshold_ff;
   logic [DIM_W-1:0]  w_eff, h_eff;
   logic              q_valid, q_pop;
   cmd_type           q_cmd;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= RST_DIM;
         map_height_ff <= RST_DIM;
         max_steps_ff  <= RST_MAX_STEPS;
         threshold_ff  <= RST_THRESHOLD;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAP_WIDTH:  map_width_ff  <= csr_wdata;
            CSR_MAP_HEIGHT: map_height_ff <= csr_wdata;
            CSR_MAX_STEPS:  max_steps_ff  <= csr_wdata;
            CSR_THRESHOLD:  threshold_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Clamp map size to the store
   assign w_eff = (32'(map_width_ff) < MAX_WIDTH)  ? DIM_W'(map_width_ff)  : DIM_W'(MAX_WIDTH);
   assign h_eff = (32'(map_height_ff) < MAX_HEIGHT) ? DIM_W'(map_height_ff) : DIM_W'(MAX_HEIGHT);

   grv_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_mode, .req_cell_x, .req_cell_y,
      .req_occupancy, .req_restart_numbering,
      .threshold(signed'(threshold_ff)),
      .q_valid, .q_cmd, .q_pop
   );

   grv_back #(.NUM_RAYS(NUM_RAYS), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
      .clock, .reset, .q_valid, .q_cmd, .q_pop, .w_eff, .h_eff,
      .max_steps(max_steps_ff),
      .rsp_valid, .rsp_ready, .rsp_point_score, .rsp_accepted, .rsp_point_number,
      .rsp_valid_rays
   );

endmodule

>>> rtl/core/grv_front.sv
// Front end: accepts request beats, classifies them and queues them for the ray walker.
// Depends on grv_pkg.
`timescale 1ns / 1ps
module grv_front import grv_pkg::*; #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_mode,
   input  logic [8:0]       req_cell_x,
   input  logic [8:0]       req_cell_y,
   input  logic signed [7:0] req_occupancy,
   input  logic             req_restart_numbering,
   input  logic signed [7:0] threshold,
   output logic             q_valid,
   output cmd_type          q_cmd,
   input  logic             q_pop
);

   cmd_type           entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              push;
   cmd_type           cmd;

   // Classify the incoming beat
   always_comb begin
      cmd.is_query = (req_mode == MODE_QUERY);
      cmd.in_range = (32'(req_cell_x) < MAX_WIDTH) && (32'(req_cell_y) < MAX_HEIGHT);
      cmd.obst     = (req_occupancy > threshold);
      cmd.restart  = req_restart_numbering;
      cmd.x        = req_cell_x;
      cmd.y        = req_cell_y;
   end

   assign req_ready = (count_ff != (QPTR_W+1)'(QDEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_cmd     = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= cmd;
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_W+1)'(QDEPTH)) else $error("queue count overflow");
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (count_ff == (QPTR_W+1)'(QDEPTH)) |-> !req_ready)
      else $error("ready while queue full");

endmodule

>>> rtl/core/grv_back.sv
// Back end: obstacle grid memory, ray walker, score divider and point counter.
// Depends on grv_pkg.
`timescale 1ns / 1ps
module grv_back import grv_pkg::*; #(
   parameter int NUM_RAYS   = 36,
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  cmd_type             q_cmd,
   output logic                q_pop,
   input  logic [DIM_W-1:0]    w_eff,
   input  logic [DIM_W-1:0]    h_eff,
   input  logic [STEP_W-1:0]   max_steps,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SCORE_W-1:0]  rsp_point_score,
   output logic                rsp_accepted,
   output logic [NUM_W-1:0]    rsp_point_number,
   output logic [5:0]          rsp_valid_rays
);

   localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int RAY_W  = $clog2(NUM_RAYS);
   localparam int CNT_W  = $clog2(NUM_RAYS + 1);
   localparam int SUM_W  = $clog2(NUM_RAYS * 1023 + 1);
   localparam int DEN_W  = CNT_W + STEP_W;
   localparam int NW     = SUM_W + FRAC_W;
   localparam int DC_W   = $clog2(NW + 1);
   localparam int CELL_W = POS_W - FRAC_W - 1;

   // Direction table, one entry per ray
   logic [2*DIR_W-1:0] dir_rom [NUM_RAYS];
   for (genvar i = 0; i < NUM_RAYS; i++) begin : g_dir
      localparam logic [31:0] PHASE = 32'((64'(i) << 32) / NUM_RAYS);
      assign dir_rom[i] = dir_of(PHASE);
   end

   logic grid_mem [MAX_WIDTH * MAX_HEIGHT];

   back_state_type state_ff, state_in;
   cmd_type        cmd_ff;
   logic [RAY_W-1:0]  ray_ff;
   logic [POS_W-1:0]  px_ff, py_ff;
   logic [STEP_W-1:0] n_ff, len_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [CNT_W-1:0]  vcnt_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [DEN_W:0]    rem_ff;
   logic [NW-1:0]     num_ff;
   logic [DC_W-1:0]   dcnt_ff;
   logic [NUM_W-1:0]  counter_ff;
   logic              rd_data_ff;

   logic [DIR_W-1:0]  ddx, ddy;
   logic [POS_W-1:0]  probe_x, probe_y;
   logic [CELL_W-1:0] gx, gy;
   logic              probe_in, last_step, ray_last, div_done, acc;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic [DEN_W:0]    rem_shift;
   logic              grid_we;

   assign ddx = dir_rom[ray_ff][2*DIR_W-1:DIR_W];
   assign ddy = dir_rom[ray_ff][DIR_W-1:0];

   // Probe position: ray origin on start, next half-cell step while walking
   always_comb begin
      if (state_ff == ST_START) begin
         probe_x = {(POS_W-25)'(0), cmd_ff.x, 16'h8000};
         probe_y = {(POS_W-25)'(0), cmd_ff.y, 16'h8000};
      end else begin
         probe_x = px_ff + {{(POS_W-DIR_W){ddx[DIR_W-1]}}, ddx};
         probe_y = py_ff + {{(POS_W-DIR_W){ddy[DIR_W-1]}}, ddy};
      end
      gx = probe_x[POS_W-2:FRAC_W];
      gy = probe_y[POS_W-2:FRAC_W];
      probe_in = !probe_x[POS_W-1] && !probe_y[POS_W-1]
              && (DIM_W'(gx) < w_eff) && (DIM_W'(gy) < h_eff);
      rd_addr = ADDR_W'(gy) * ADDR_W'(MAX_WIDTH) + ADDR_W'(gx);
      wr_addr = ADDR_W'(q_cmd.y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(q_cmd.x);
      last_step = ((STEP_W+1)'(n_ff) + 1'b1) >= (STEP_W+1)'(max_steps);
      ray_last  = (32'(ray_ff) == NUM_RAYS - 1);
      div_done  = (32'(dcnt_ff) == NW);
      rem_shift = {rem_ff[DEN_W-1:0], num_ff[NW-1]};
      acc       = ({sum_ff, 1'b0} > (SUM_W+1)'(den_ff)) && (vcnt_ff != '0);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (q_valid && q_cmd.is_query) state_in = ST_START;
         ST_START:  if (max_steps != '0 && probe_in) state_in = ST_WALK;
                    else state_in = ST_RAYEND;
         ST_WALK:   if (rd_data_ff || last_step || !probe_in) state_in = ST_RAYEND;
         ST_RAYEND: state_in = ray_last ? ST_MUL : ST_START;
         ST_MUL:    state_in = ST_DIV;
         ST_DIV:    if (div_done) state_in = ST_FIN;
         ST_FIN:    state_in = ST_OUT;
         ST_OUT:    if (rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Handshake outputs
   always_comb begin
      q_pop     = 1'b0;
      grid_we   = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            q_pop   = q_valid;
            grid_we = q_valid && !q_cmd.is_query && q_cmd.in_range;
         end
         ST_OUT:  rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         counter_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_IDLE && q_valid && q_cmd.is_query && q_cmd.restart)
            counter_ff <= '0;
         else if (state_ff == ST_FIN && acc)
            counter_ff <= counter_ff + 1'b1;
      end
   end

   // Grid store: write from the queue, read at the probe cell
   always_ff @(posedge clock) begin
      if (grid_we) grid_mem[wr_addr] <= q_cmd.obst;
      if (probe_in) rd_data_ff <= grid_mem[rd_addr];
   end

   // Walk datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            cmd_ff  <= q_cmd;
            ray_ff  <= '0;
            sum_ff  <= '0;
            vcnt_ff <= '0;
         end
         ST_START: begin
            px_ff  <= probe_x;
            py_ff  <= probe_y;
            n_ff   <= '0;
            len_ff <= max_steps;
         end
         ST_WALK: begin
            px_ff <= probe_x;
            py_ff <= probe_y;
            n_ff  <= n_ff + 1'b1;
            if (rd_data_ff) len_ff <= n_ff;
            else            len_ff <= max_steps;
         end
         ST_RAYEND: begin
            if (len_ff != '0) begin
               sum_ff  <= sum_ff + SUM_W'(len_ff);
               vcnt_ff <= vcnt_ff + 1'b1;
            end
            ray_ff <= ray_last ? '0 : ray_ff + 1'b1;
         end
         ST_MUL: begin
            den_ff  <= DEN_W'(vcnt_ff) * DEN_W'(max_steps);
            num_ff  <= {sum_ff, FRAC_W'(0)};
            rem_ff  <= '0;
            dcnt_ff <= '0;
         end
         ST_DIV: begin
            // one restoring division bit per cycle
            if (!div_done) begin
               dcnt_ff <= dcnt_ff + 1'b1;
               if (rem_shift >= {1'b0, den_ff}) begin
                  rem_ff <= rem_shift - {1'b0, den_ff};
                  num_ff <= {num_ff[NW-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_shift;
                  num_ff <= {num_ff[NW-2:0], 1'b0};
               end
            end
         end
         ST_FIN: begin
            rsp_point_score  <= (vcnt_ff == '0) ? '0 : num_ff[SCORE_W-1:0];
            rsp_accepted     <= acc;
            rsp_point_number <= counter_ff;
            rsp_valid_rays   <= 6'(vcnt_ff);
         end
         default: ;
      endcase
   end

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == ST_IDLE) else $error("queue popped while busy");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && acc) |=> counter_ff == $past(counter_ff) + 1'b1)
      else $error("accepted point not counted");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_point_score)
         && $stable(rsp_point_number) && $stable(rsp_valid_rays))
      else $error("result beat changed while waiting");

endmodule
